[sv/pcpa_pkg.sv]
// shared types, constants and helpers for the per-cpu page allocator
package pcpa_pkg;

    localparam int CPUS       = 8;
    localparam int PAGES      = 65536;
    localparam int PAGE_SHIFT = 12;

    localparam int ADDR_W     = 32;
    localparam int CPU_W      = 3;
    localparam int STATUS_W   = 2;
    localparam int PAGE_W     = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int CPU_IDX_W  = (CPUS > 1) ? $clog2(CPUS) : 1;
    localparam int LINK_W     = PAGE_W + 1;
    localparam int CFG_ADDR_W = 3;

    localparam logic OP_FREE  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd2;

    localparam logic REG_MEM_START = 1'b0;
    localparam logic REG_MEM_STOP  = 1'b1;

    localparam logic [ADDR_W-1:0] MEM_START_RESET = 32'd0;
    localparam logic [ADDR_W-1:0] MEM_STOP_RESET  = 32'd134217728;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_READ
    } state_t;

    typedef struct packed {
        logic capture;
        logic push;
        logic reject;
        logic empty;
        logic read;
        logic pop;
    } pcpa_cmd_t;

    typedef struct packed {
        logic is_alloc;
        logic free_ok;
        logic found;
        logic out_valid;
    } pcpa_sts_t;

    function automatic logic [ADDR_W-1:0] page_to_addr(input logic [PAGE_W-1:0] page);
        logic [PAGE_W+PAGE_SHIFT-1:0] wide;
        wide = {page, {PAGE_SHIFT{1'b0}}};
        return ADDR_W'(wide);
    endfunction

endpackage

[sv/per_cpu_page_free_list_allocator.sv]
// Per-CPU page-frame allocator: one LIFO free list per CPU threaded through a
// link memory indexed by page number. A request word is taken only while the
// block is idle and its result register is empty or being emptied. A free, a
// rejected free and an allocate that finds every list empty load their result
// register from the evaluate state; an allocate that pops a page loads it from
// the read state, after the registered read of the link memory. The next word
// can be taken in the cycle after the result is loaded, if the result is taken
// at once. The link memory needs no clearing after reset, so the block is
// ready as soon as reset is released. Registers: mem_start at 0x0 and mem_stop
// at 0x4; software fills the lists by issuing frees.
module per_cpu_page_free_list_allocator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                op,
    input  logic [pcpa_pkg::CPU_W-1:0]          cpu,
    input  logic [pcpa_pkg::ADDR_W-1:0]         address,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [pcpa_pkg::STATUS_W-1:0]       status,
    output logic [pcpa_pkg::ADDR_W-1:0]         page_address,
    output logic [pcpa_pkg::CPU_W-1:0]          source_cpu,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pcpa_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    logic [pcpa_pkg::ADDR_W-1:0] mem_start_reg;
    logic [pcpa_pkg::ADDR_W-1:0] mem_stop_reg;
    logic                        cfg_write;
    pcpa_pkg::pcpa_cmd_t         cmd;
    pcpa_pkg::pcpa_sts_t         sts;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_start_reg <= pcpa_pkg::MEM_START_RESET;
            mem_stop_reg  <= pcpa_pkg::MEM_STOP_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == pcpa_pkg::REG_MEM_START)
            begin
                mem_start_reg <= pwdata;
            end
            else
            begin
                mem_stop_reg <= pwdata;
            end
        end
    end

    assign prdata = (paddr[2] == pcpa_pkg::REG_MEM_STOP) ? mem_stop_reg : mem_start_reg;

    pcpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pcpa_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .op           (op),
        .cpu          (cpu),
        .address      (address),
        .mem_start    (mem_start_reg),
        .mem_stop     (mem_stop_reg),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .status       (status),
        .page_address (page_address),
        .source_cpu   (source_cpu)
    );

endmodule

[sv/pcpa_ctrl.sv]
// controller state machine sequencing each request word through the datapath
module pcpa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                out_ready,
    input  pcpa_pkg::pcpa_sts_t sts,
    output pcpa_pkg::pcpa_cmd_t cmd
);

    pcpa_pkg::state_t state_reg;
    pcpa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pcpa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == pcpa_pkg::ST_IDLE) && (!sts.out_valid || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pcpa_pkg::ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    state_next = pcpa_pkg::ST_EVAL;
                end
            end
            pcpa_pkg::ST_EVAL:
            begin
                if (sts.is_alloc && sts.found)
                begin
                    state_next = pcpa_pkg::ST_READ;
                end
                else
                begin
                    state_next = pcpa_pkg::ST_IDLE;
                end
            end
            pcpa_pkg::ST_READ:
            begin
                state_next = pcpa_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pcpa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            pcpa_pkg::ST_IDLE:
            begin
                cmd.capture = in_valid && in_ready;
            end
            pcpa_pkg::ST_EVAL:
            begin
                if (!sts.is_alloc)
                begin
                    cmd.push   = sts.free_ok;
                    cmd.reject = !sts.free_ok;
                end
                else
                begin
                    cmd.read  = sts.found;
                    cmd.empty = !sts.found;
                end
            end
            pcpa_pkg::ST_READ:
            begin
                cmd.pop = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[sv/pcpa_datapath.sv]
// list heads, link memory, request checks and result register
module pcpa_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pcpa_pkg::pcpa_cmd_t                 cmd,
    output pcpa_pkg::pcpa_sts_t                 sts,
    input  logic                                op,
    input  logic [pcpa_pkg::CPU_W-1:0]          cpu,
    input  logic [pcpa_pkg::ADDR_W-1:0]         address,
    input  logic [pcpa_pkg::ADDR_W-1:0]         mem_start,
    input  logic [pcpa_pkg::ADDR_W-1:0]         mem_stop,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [pcpa_pkg::STATUS_W-1:0]       status,
    output logic [pcpa_pkg::ADDR_W-1:0]         page_address,
    output logic [pcpa_pkg::CPU_W-1:0]          source_cpu
);

    logic                              op_reg;
    logic [pcpa_pkg::CPU_W-1:0]        cpu_reg;
    logic [pcpa_pkg::ADDR_W-1:0]       addr_reg;
    logic [pcpa_pkg::PAGE_W-1:0]       head_reg [pcpa_pkg::CPUS];
    logic [pcpa_pkg::CPUS-1:0]         head_valid_reg;
    logic [pcpa_pkg::CPU_IDX_W-1:0]    src_reg;
    logic [pcpa_pkg::LINK_W-1:0]       rdata_reg;
    logic                              out_valid_reg;
    logic [pcpa_pkg::STATUS_W-1:0]     status_reg;
    logic [pcpa_pkg::ADDR_W-1:0]       page_address_reg;
    logic [pcpa_pkg::CPU_W-1:0]        source_cpu_reg;

    logic [pcpa_pkg::LINK_W-1:0]       link_mem [pcpa_pkg::PAGES];

    logic [pcpa_pkg::ADDR_W-1:0]       page_full;
    logic [pcpa_pkg::PAGE_W-1:0]       page_idx;
    logic [pcpa_pkg::CPU_IDX_W-1:0]    own;
    logic                              cpu_ok;
    logic                              free_ok;
    logic                              found;
    logic [pcpa_pkg::CPU_IDX_W-1:0]    sel;
    logic                              load;

    assign page_full = addr_reg >> pcpa_pkg::PAGE_SHIFT;
    assign page_idx  = page_full[pcpa_pkg::PAGE_W-1:0];
    assign own       = pcpa_pkg::CPU_IDX_W'(cpu_reg);
    assign cpu_ok    = int'(cpu_reg) < pcpa_pkg::CPUS;

    assign free_ok = (addr_reg[pcpa_pkg::PAGE_SHIFT-1:0] == '0)
                  && (addr_reg >= mem_start)
                  && (addr_reg < mem_stop)
                  && (page_full < pcpa_pkg::ADDR_W'(pcpa_pkg::PAGES))
                  && cpu_ok;

    // own list first, else lowest-numbered nonempty list
    always_comb
    begin
        found = 1'b0;
        sel   = '0;
        if (cpu_ok && head_valid_reg[own])
        begin
            found = 1'b1;
            sel   = own;
        end
        else
        begin
            for (int i = 0; i < pcpa_pkg::CPUS; i++)
            begin
                if (!found && head_valid_reg[i])
                begin
                    found = 1'b1;
                    sel   = pcpa_pkg::CPU_IDX_W'(i);
                end
            end
        end
    end

    assign sts.is_alloc  = (op_reg == pcpa_pkg::OP_ALLOC);
    assign sts.free_ok   = free_ok;
    assign sts.found     = found;
    assign sts.out_valid = out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= op;
            cpu_reg  <= cpu;
            addr_reg <= address;
        end
        if (cmd.read)
        begin
            src_reg <= sel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            link_mem[page_idx] <= {head_valid_reg[own], head_reg[own]};
        end
        if (cmd.read)
        begin
            rdata_reg <= link_mem[head_reg[sel]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            head_reg[own] <= page_idx;
        end
        else if (cmd.pop)
        begin
            head_reg[src_reg] <= rdata_reg[pcpa_pkg::PAGE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= '0;
        end
        else if (cmd.push)
        begin
            head_valid_reg[own] <= 1'b1;
        end
        else if (cmd.pop)
        begin
            head_valid_reg[src_reg] <= rdata_reg[pcpa_pkg::PAGE_W];
        end
    end

    assign load = cmd.push || cmd.reject || cmd.empty || cmd.pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pop)
        begin
            status_reg       <= pcpa_pkg::STATUS_OK;
            page_address_reg <= pcpa_pkg::page_to_addr(head_reg[src_reg]);
            source_cpu_reg   <= pcpa_pkg::CPU_W'(src_reg);
        end
        else if (load)
        begin
            page_address_reg <= '0;
            source_cpu_reg   <= '0;
            if (cmd.reject)
            begin
                status_reg <= pcpa_pkg::STATUS_REJECT;
            end
            else if (cmd.empty)
            begin
                status_reg <= pcpa_pkg::STATUS_EMPTY;
            end
            else
            begin
                status_reg <= pcpa_pkg::STATUS_OK;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign page_address = page_address_reg;
    assign source_cpu   = source_cpu_reg;

endmodule

[sv/pcpa_checker.sv]
// port-level checks for the page allocator, bound to the top level
module pcpa_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                op,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [pcpa_pkg::STATUS_W-1:0]       status,
    input logic [pcpa_pkg::ADDR_W-1:0]         page_address,
    input logic [pcpa_pkg::CPU_W-1:0]          source_cpu
);

    // failed or empty requests carry no page
    a_no_page_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != pcpa_pkg::STATUS_OK)
            |-> (page_address == '0) && (source_cpu == '0))
        else $error("page returned with failing status");

    // one word in flight: busy right after acceptance
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second word taken while first in flight");

    // a free always answers from the evaluate state, with no link memory read
    a_free_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (op == pcpa_pkg::OP_FREE) |=> ##1 out_valid)
        else $error("free result late");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(page_address)
            && $stable(source_cpu))
        else $error("stalled result changed");

endmodule

bind per_cpu_page_free_list_allocator pcpa_checker u_pcpa_checker (.*);
